// File: design/phs_pkg.sv
`timescale 1ns / 1ps

package phs_pkg;

  localparam int unsigned ID_W   = 39;
  localparam int unsigned ID_LSB = 24;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX2   = 64'h94d049bb133111eb;

  localparam int unsigned SHIFT1 = 30;
  localparam int unsigned SHIFT2 = 27;
  localparam int unsigned SHIFT3 = 31;

  localparam logic [CFG_INDEX_W-1:0] CFG_EXPANDED_IDS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_ENABLE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_THRESHOLD = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HASH_SEED      = 2'd3;

  typedef struct packed {
    logic        expanded_ids;
    logic        sample_enable;
    logic [63:0] keep_threshold;
    logic [63:0] hash_seed;
  } cfg_t;

  typedef struct packed {
    logic            id_valid;
    logic [ID_W-1:0] particle_id;
  } side_t;

endpackage

// File: design/phs_decode.sv
`timescale 1ns / 1ps

module phs_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  logic signed [31:0] first_word,
  input  logic signed [31:0] second_word,
  input  phs_pkg::cfg_t      cfg,
  output logic               vld_o,
  output phs_pkg::side_t     side_o,
  output logic [63:0]        v_o
);

  logic                     vld_r;
  phs_pkg::side_t           side_r;
  phs_pkg::side_t           side_nxt;
  logic [63:0]              v_r;
  logic [63:0]              v_nxt;
  logic [63:0]              packed_w;

  always_comb begin
    packed_w = {first_word, second_word};
    side_nxt.id_valid    = 1'b0;
    side_nxt.particle_id = '0;
    if (!cfg.expanded_ids) begin
      side_nxt.id_valid = !first_word[31] && (first_word != 32'sd0);
      if (side_nxt.id_valid) begin
        side_nxt.particle_id = {{(phs_pkg::ID_W-32){1'b0}}, first_word};
      end
    end else begin
      side_nxt.id_valid = packed_w[63];
      if (side_nxt.id_valid) begin
        side_nxt.particle_id = packed_w[phs_pkg::ID_LSB +: phs_pkg::ID_W];
      end
    end
    v_nxt = ({{(64-phs_pkg::ID_W){1'b0}}, side_nxt.particle_id} ^ cfg.hash_seed)
            + phs_pkg::GOLDEN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    side_r <= side_nxt;
    v_r    <= v_nxt;
  end

  assign vld_o  = vld_r;
  assign side_o = side_r;
  assign v_o    = v_r;

endmodule

// File: design/phs_mul64.sv
`timescale 1ns / 1ps

module phs_mul64 #(
  parameter int unsigned SHIFT = phs_pkg::SHIFT1,
  parameter logic [63:0] MULT  = phs_pkg::MIX1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  phs_pkg::side_t side_i,
  input  logic [63:0]    v_i,
  output logic           vld_o,
  output phs_pkg::side_t side_o,
  output logic [63:0]    m_o
);

  logic [63:0]    x_nxt;
  logic           vld_a_r, vld_b_r, vld_c_r;
  phs_pkg::side_t side_a_r, side_b_r, side_c_r;
  logic [63:0]    x_a_r;
  logic [31:0]    xlo_b_r;
  logic [63:0]    acc_a_r, acc_b_r, acc_c_r;
  logic [31:0]    cross_hi;
  logic [31:0]    cross_lo;

  always_comb begin
    x_nxt    = v_i ^ (v_i >> SHIFT);
    cross_hi = x_a_r[63:32] * MULT[31:0];
    cross_lo = xlo_b_r * MULT[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else begin
      vld_a_r <= vld_i;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
    side_a_r <= side_i;
    x_a_r    <= x_nxt;
    acc_a_r  <= {32'b0, x_nxt[31:0]} * {32'b0, MULT[31:0]};
    side_b_r <= side_a_r;
    xlo_b_r  <= x_a_r[31:0];
    acc_b_r  <= acc_a_r + {cross_hi, 32'b0};
    side_c_r <= side_b_r;
    acc_c_r  <= acc_b_r + {cross_lo, 32'b0};
  end

  assign vld_o  = vld_c_r;
  assign side_o = side_c_r;
  assign m_o    = acc_c_r;

endmodule

// File: design/phs_final.sv
`timescale 1ns / 1ps

module phs_final (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_i,
  input  phs_pkg::side_t            side_i,
  input  logic [63:0]               m_i,
  input  phs_pkg::cfg_t             cfg,
  output logic                      out_valid,
  output logic                      out_id_valid,
  output logic                      out_keep,
  output logic [phs_pkg::ID_W-1:0]  out_particle_id
);

  logic [63:0]             hash;
  logic                    keep_nxt;
  logic                    vld_r;
  logic                    id_valid_r;
  logic                    keep_r;
  logic [phs_pkg::ID_W-1:0] id_r;

  always_comb begin
    hash     = m_i ^ (m_i >> phs_pkg::SHIFT3);
    keep_nxt = side_i.id_valid && cfg.sample_enable && (hash <= cfg.keep_threshold);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    id_valid_r <= side_i.id_valid;
    keep_r     <= keep_nxt;
    id_r       <= side_i.particle_id;
  end

  assign out_valid       = vld_r;
  assign out_id_valid    = id_valid_r;
  assign out_keep        = keep_r;
  assign out_particle_id = id_r;

  a_keep_needs_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_keep |-> out_id_valid)
    else $error("Kept word without a valid id.");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_id_valid |-> (out_particle_id == '0) && !out_keep)
    else $error("Invalid id word carries a nonzero id or keep.");

  a_strobe_follows: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> out_valid == $past(vld_i))
    else $error("Result strobe lost or invented in the last stage.");

endmodule

// File: design/particle_id_hash_sampler_top.sv
`timescale 1ns / 1ps

// Particle id decoder and hash sampler.
// Input words: drive in_first_word and in_second_word with start high; a word
// is taken at each rising edge where start is high and busy is low. Busy is
// always low, so one word can be taken in every cycle.
// Result words: out_valid is high for one cycle with out_id_valid, out_keep
// and out_particle_id. A word passes the decode register, the multiply stages
// and the final register; the throughput is one word per cycle.
// The depth is set by the two 64-bit constant multiplies of the hash, each
// built from three 32-bit partial products over three register stages.
// Configuration: cfg_we with cfg_index and cfg_wdata writes one register at
// the clock edge; write only while no word is in flight.
// Reset: rst_n low clears the pipeline valid bits and restores the register
// defaults (legacy ids, sampling off, threshold all ones, seed zero).
// The receiver cannot stall; results are never held back or dropped.
module particle_id_hash_sampler_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [31:0]                  in_first_word,
  input  logic signed [31:0]                  in_second_word,
  output logic                                out_valid,
  output logic                                out_id_valid,
  output logic                                out_keep,
  output logic [phs_pkg::ID_W-1:0]            out_particle_id,
  input  logic                                cfg_we,
  input  logic [phs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [63:0]                         cfg_wdata
);

  phs_pkg::cfg_t  cfg_r;
  logic           accept;
  logic           vld_d, vld_m1, vld_m2;
  phs_pkg::side_t side_d, side_m1, side_m2;
  logic [63:0]    v_d, m_m1, m_m2;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expanded_ids   <= 1'b0;
      cfg_r.sample_enable  <= 1'b0;
      cfg_r.keep_threshold <= '1;
      cfg_r.hash_seed      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        phs_pkg::CFG_EXPANDED_IDS:   cfg_r.expanded_ids   <= cfg_wdata[0];
        phs_pkg::CFG_SAMPLE_ENABLE:  cfg_r.sample_enable  <= cfg_wdata[0];
        phs_pkg::CFG_KEEP_THRESHOLD: cfg_r.keep_threshold <= cfg_wdata;
        phs_pkg::CFG_HASH_SEED:      cfg_r.hash_seed      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  phs_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .vld_i       (accept),
    .first_word  (in_first_word),
    .second_word (in_second_word),
    .cfg         (cfg_r),
    .vld_o       (vld_d),
    .side_o      (side_d),
    .v_o         (v_d)
  );

  phs_mul64 #(
    .SHIFT (phs_pkg::SHIFT1),
    .MULT  (phs_pkg::MIX1)
  ) u_mul1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld_d),
    .side_i (side_d),
    .v_i    (v_d),
    .vld_o  (vld_m1),
    .side_o (side_m1),
    .m_o    (m_m1)
  );

  phs_mul64 #(
    .SHIFT (phs_pkg::SHIFT2),
    .MULT  (phs_pkg::MIX2)
  ) u_mul2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (vld_m1),
    .side_i (side_m1),
    .v_i    (m_m1),
    .vld_o  (vld_m2),
    .side_o (side_m2),
    .m_o    (m_m2)
  );

  phs_final u_final (
    .clk             (clk),
    .rst_n           (rst_n),
    .vld_i           (vld_m2),
    .side_i          (side_m2),
    .m_i             (m_m2),
    .cfg             (cfg_r),
    .out_valid       (out_valid),
    .out_id_valid    (out_id_valid),
    .out_keep        (out_keep),
    .out_particle_id (out_particle_id)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NUM_ROWS = 21;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned WORDS_PER_PHASE = 300;
  localparam int unsigned TAIL_CYCLES = 16;

  typedef enum logic [2:0] {
    PRESET_RESET,
    PRESET_EXP_OFF,
    PRESET_EXP_FULL,
    PRESET_LEG_ZERO,
    PRESET_LEG_HALF
  } preset_t;

  typedef struct packed {
    logic                     id_valid;
    logic                     keep;
    logic [phs_pkg::ID_W-1:0] particle_id;
  } sample_t;

  typedef struct packed {
    preset_t     preset;
    logic [31:0] first;
    logic [31:0] second;
    logic        known;
    sample_t     result;
  } row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  logic signed [31:0]              in_first_word;
  logic signed [31:0]              in_second_word;
  logic                            out_valid;
  logic                            out_id_valid;
  logic                            out_keep;
  logic [phs_pkg::ID_W-1:0]        out_particle_id;
  logic                            cfg_we;
  logic [phs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [63:0]                     cfg_wdata;

  logic        row_known;
  sample_t     row_result;
  logic        cur_expanded;
  logic        cur_sample_enable;
  logic [63:0] cur_keep_threshold;
  logic [63:0] cur_hash_seed;

  sample_t     pending_samples[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  row_t        directed_rows [NUM_ROWS];

  particle_id_hash_sampler_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_first_word   (in_first_word),
    .in_second_word  (in_second_word),
    .out_valid       (out_valid),
    .out_id_valid    (out_id_valid),
    .out_keep        (out_keep),
    .out_particle_id (out_particle_id),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] splitmix_finalize(input logic [63:0] v);
    v = v + phs_pkg::GOLDEN;
    v = (v ^ (v >> phs_pkg::SHIFT1)) * phs_pkg::MIX1;
    v = (v ^ (v >> phs_pkg::SHIFT2)) * phs_pkg::MIX2;
    return v ^ (v >> phs_pkg::SHIFT3);
  endfunction

  function automatic sample_t predict_sample(input logic [31:0] a, input logic [31:0] b);
    sample_t     r;
    logic [63:0] joined;
    r = '0;
    joined = {a, b};
    if (!cur_expanded) begin
      r.id_valid = !a[31] && (a != 32'd0);
      if (r.id_valid) begin
        r.particle_id[31:0] = a;
      end
    end else begin
      r.id_valid = joined[63];
      if (r.id_valid) begin
        r.particle_id = joined[phs_pkg::ID_LSB +: phs_pkg::ID_W];
      end
    end
    if (r.id_valid && cur_sample_enable) begin
      r.keep = splitmix_finalize(64'(r.particle_id) ^ cur_hash_seed) <= cur_keep_threshold;
    end
    return r;
  endfunction

  task automatic note_expected(input sample_t s);
    pending_samples = {pending_samples, s};
  endtask

  always @(posedge clk) begin : result_check
    sample_t want;
    if (!rst_n) begin
      cur_expanded <= 1'b0;
      cur_sample_enable <= 1'b0;
      cur_keep_threshold <= '1;
      cur_hash_seed <= '0;
    end else begin
      if (out_valid) begin
        if (pending_samples.size() == 0) begin
          $error("result word with nothing expected: id_valid %0d keep %0d particle_id 0x%0h",
                 out_id_valid, out_keep, out_particle_id);
          fail_count++;
        end else begin
          want = pending_samples.pop_front();
          if (out_id_valid !== want.id_valid) begin
            $error("id_valid: expected %0d, actual %0d", want.id_valid, out_id_valid);
            fail_count++;
          end
          if (out_keep !== want.keep) begin
            $error("keep: expected %0d, actual %0d", want.keep, out_keep);
            fail_count++;
          end
          if (out_particle_id !== want.particle_id) begin
            $error("particle_id: expected 0x%0h, actual 0x%0h", want.particle_id,
                   out_particle_id);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        note_expected(row_known ? row_result :
                      predict_sample(in_first_word, in_second_word));
      end
      if (cfg_we) begin
        case (cfg_index)
          phs_pkg::CFG_EXPANDED_IDS:   cur_expanded <= cfg_wdata[0];
          phs_pkg::CFG_SAMPLE_ENABLE:  cur_sample_enable <= cfg_wdata[0];
          phs_pkg::CFG_KEEP_THRESHOLD: cur_keep_threshold <= cfg_wdata;
          phs_pkg::CFG_HASH_SEED:      cur_hash_seed <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic [31:0] a, input logic [31:0] b, input logic known,
                           input sample_t result);
    in_first_word <= a;
    in_second_word <= b;
    row_known <= known;
    row_result <= result;
    start <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_for(input int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (pending_samples.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_regs(input logic expanded, input logic enable, input logic [63:0] thr,
                            input logic [63:0] seed);
    logic [63:0] junk;
    junk = {$urandom(), $urandom()};
    cfg_we <= 1'b1;
    cfg_index <= phs_pkg::CFG_EXPANDED_IDS;
    cfg_wdata <= {junk[63:1], expanded};
    @(posedge clk);
    junk = {$urandom(), $urandom()};
    cfg_index <= phs_pkg::CFG_SAMPLE_ENABLE;
    cfg_wdata <= {junk[63:1], enable};
    @(posedge clk);
    cfg_index <= phs_pkg::CFG_KEEP_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_index <= phs_pkg::CFG_HASH_SEED;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_preset(input preset_t p);
    case (p)
      PRESET_EXP_OFF:  write_regs(1'b1, 1'b0, '1, {$urandom(), $urandom()});
      PRESET_EXP_FULL: write_regs(1'b1, 1'b1, '1, {$urandom(), $urandom()});
      PRESET_LEG_ZERO: write_regs(1'b0, 1'b1, '0, '0);
      PRESET_LEG_HALF: write_regs(1'b0, 1'b1, 64'h8000_0000_0000_0000, '1);
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 30);
  endfunction

  initial begin
    preset_t     cur_preset;
    logic        ph_expanded;
    logic        ph_enable;
    logic [63:0] ph_thr;
    logic [63:0] ph_seed;
    logic [31:0] a;
    logic [31:0] b;
    int unsigned r;

    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_first_word = '0;
    in_second_word = '0;
    cfg_we = 1'b0;
    cfg_index = phs_pkg::CFG_EXPANDED_IDS;
    cfg_wdata = '0;
    row_known = 1'b0;
    row_result = '0;
    cur_preset = PRESET_RESET;

    directed_rows = '{
      '{PRESET_RESET,    32'h0000_0001, 32'h0000_0000, 1'b1, '{1'b1, 1'b0, 39'd1}},
      '{PRESET_RESET,    32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 39'h7FFF_FFFF}},
      '{PRESET_RESET,    32'h0000_0000, 32'h1234_5678, 1'b1, '{1'b0, 1'b0, 39'd0}},
      '{PRESET_RESET,    32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 39'd0}},
      '{PRESET_RESET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 39'd0}},
      '{PRESET_RESET,    32'h1234_5678, 32'h8000_0000, 1'b1, '{1'b1, 1'b0, 39'h1234_5678}},
      '{PRESET_EXP_OFF,  32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 1'b0, 39'd0}},
      '{PRESET_EXP_OFF,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 39'h7F_FFFF_FFFF}},
      '{PRESET_EXP_OFF,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 39'd0}},
      '{PRESET_EXP_OFF,  32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 39'd0}},
      '{PRESET_EXP_OFF,  32'h8000_0000, 32'h00FF_FFFF, 1'b1, '{1'b1, 1'b0, 39'd0}},
      '{PRESET_EXP_OFF,  32'h8000_0000, 32'h0100_0000, 1'b1, '{1'b1, 1'b0, 39'd1}},
      '{PRESET_EXP_FULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b1, 39'h7F_FFFF_FFFF}},
      '{PRESET_EXP_FULL, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 1'b1, 39'd0}},
      '{PRESET_EXP_FULL, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 39'd0}},
      '{PRESET_EXP_FULL, 32'hC000_0000, 32'h1234_5678, 1'b0, '0},
      '{PRESET_LEG_ZERO, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
      '{PRESET_LEG_ZERO, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{PRESET_LEG_ZERO, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b0, 1'b0, 39'd0}},
      '{PRESET_LEG_HALF, 32'h0000_0042, 32'h0000_0000, 1'b0, '0},
      '{PRESET_LEG_HALF, 32'h4000_0000, 32'hFFFF_FFFF, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (directed_rows[i].preset != cur_preset) begin
        drain_results();
        apply_preset(directed_rows[i].preset);
        cur_preset = directed_rows[i].preset;
      end
      send_word(directed_rows[i].first, directed_rows[i].second, directed_rows[i].known,
                directed_rows[i].result);
      idle_for(pick_gap());
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      ph_expanded = p[0];
      ph_enable = (p != 4);
      r = $urandom_range(0, 3);
      ph_thr = (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom(), $urandom()};
      ph_seed = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom(), $urandom()};
      if (p == 0) begin
        ph_thr = '1;
      end else if (p == 1) begin
        ph_thr = '0;
      end
      drain_results();
      write_regs(ph_expanded, ph_enable, ph_thr, ph_seed);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        a = $urandom();
        b = $urandom();
        r = $urandom_range(0, 99);
        if (ph_expanded) begin
          if (r < 75) begin
            a[31] = 1'b1;
          end else if (r < 80) begin
            a = 32'd0;
          end
        end else begin
          if (r < 65) begin
            a[31] = 1'b0;
          end else if (r < 70) begin
            a = 32'd0;
          end else if (r < 75) begin
            a = 32'h8000_0000;
          end else if (r < 85) begin
            a = $urandom_range(1, 255);
          end
        end
        send_word(a, b, 1'b0, '0);
        if (p == 1 && n == WORDS_PER_PHASE / 2) begin
          drain_results();
        end else if (p != 3) begin
          idle_for(pick_gap());
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/phs_pkg.sv
design/phs_decode.sv
design/phs_mul64.sv
design/phs_final.sv
design/particle_id_hash_sampler_top.sv
tb/sv/tb.sv
